// ===== hw/rtl/integer_string_parser_base_detect_unit_macros.svh =====
// Assertion macros for the parser RTL, used by the queue.
`ifndef INTEGER_STRING_PARSER_BASE_DETECT_UNIT_MACROS_SVH
`define INTEGER_STRING_PARSER_BASE_DETECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISPBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ispbd assertion failed");

// Next-cycle implication, disabled during reset.
`define ISPBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ispbd assertion failed");

`endif

// ===== hw/rtl/ispbd_pkg.sv =====
// Types and constants for the integer string parser.
package ispbd_pkg;

  localparam int OffsetW = 16;
  localparam int CountW  = (OffsetW < 16) ? OffsetW : 16;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  localparam logic [5:0] BaseAuto  = 6'd0;
  localparam logic [5:0] BaseOct   = 6'd8;
  localparam logic [5:0] BaseDec   = 6'd10;
  localparam logic [5:0] BaseHex   = 6'd16;
  localparam logic [5:0] BaseReset = BaseDec;

  localparam logic [4:0] DigitNone = 5'd16;

  typedef struct packed {
    logic       start;
    logic       blank;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       ex;
    logic [4:0] digit;
  } cls_t;

endpackage

// ===== hw/rtl/ispbd_in_if.sv =====
// Input character channel.
interface ispbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       start_flag;

  modport source (output valid, output char_in, output start_flag, input ready);
  modport sink   (input valid, input char_in, input start_flag, output ready);
endinterface

// ===== hw/rtl/ispbd_out_if.sv =====
// Result channel.
interface ispbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] parsed_value;
  logic [15:0]        end_offset;

  modport source (output valid, output parsed_value, output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

// ===== hw/rtl/ispbd_cfg_if.sv =====
// Configuration write channel.
interface ispbd_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] number_base;

  modport source (output valid, output number_base, input ready);
  modport sink   (input valid, input number_base, output ready);
endinterface

// ===== hw/rtl/integer_string_parser_base_detect_unit.sv =====
// Top level of the streaming strtol-style integer parser.
// Throughput: one character per cycle unless a result waits on out_o.ready; 32x6 multiply-add.
// A stopping character goes through the queue, then loads the result register behind out_o.
// A four-entry queue parts the classifying front from the parsing back end.
// Reset: parse idle, queue empty, no result pending, number_base back to 10.
module integer_string_parser_base_detect_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ispbd_in_if.sink    in_i,
  ispbd_cfg_if.sink   cfg_i,
  ispbd_out_if.source out_o
);

  logic            push, full, pop, empty;
  ispbd_pkg::cls_t cls_f, cls_b;

  ispbd_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cls_o  (cls_f)
  );

  ispbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cls_i   (cls_f),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cls_o   (cls_b)
  );

  ispbd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cls_i   (cls_b),
    .pop_o   (pop),
    .cfg_i   (cfg_i),
    .out_o   (out_o)
  );

endmodule

// ===== hw/rtl/ispbd_front.sv =====
// Front end: accepts characters and classifies them for the queue.
module ispbd_front (
  ispbd_in_if.sink       in_i,
  input  logic           full_i,
  output logic           push_o,
  output ispbd_pkg::cls_t cls_o
);

  logic [7:0] c;

  assign c         = in_i.char_in;
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  always_comb begin
    cls_o.start = in_i.start_flag;
    cls_o.blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                  (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
    cls_o.plus  = (c == 8'h2B);
    cls_o.minus = (c == 8'h2D);
    cls_o.zero  = (c == 8'h30);
    cls_o.ex    = (c == 8'h78) || (c == 8'h58);
    if (c >= 8'h30 && c <= 8'h39) begin
      cls_o.digit = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      cls_o.digit = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      cls_o.digit = 5'(c - 8'h41 + 8'd10);
    end else begin
      cls_o.digit = ispbd_pkg::DigitNone;
    end
  end

endmodule

// ===== hw/rtl/ispbd_fifo.sv =====
// Short queue of classified characters between front and back.
`include "integer_string_parser_base_detect_unit_macros.svh"

module ispbd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ispbd_pkg::cls_t      cls_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ispbd_pkg::cls_t      cls_o
);

  ispbd_pkg::cls_t                mem_q [ispbd_pkg::QDepth];
  logic [ispbd_pkg::PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [ispbd_pkg::CntW-1:0]     cnt_q, cnt_d;

  localparam logic [ispbd_pkg::PtrW-1:0] PtrLast = ispbd_pkg::PtrW'(ispbd_pkg::QDepth - 1);
  localparam logic [ispbd_pkg::CntW-1:0] CntFull = ispbd_pkg::CntW'(ispbd_pkg::QDepth);

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign cls_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cls_i;
    end
  end

  `ISPBD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntFull)
  `ISPBD_ASSERT_NOW(a_pop_nonempty, pop_i, cnt_q != '0)
  `ISPBD_ASSERT_NEXT(a_push_grows, push_i && !pop_i, cnt_q == ispbd_pkg::CntW'($past(cnt_q) + 1'b1))

endmodule

// ===== hw/rtl/ispbd_back.sv =====
// Back end: parse state machine, multiply-add and result register.
module ispbd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ispbd_pkg::cls_t cls_i,
  output logic            pop_o,
  ispbd_cfg_if.sink       cfg_i,
  ispbd_out_if.source     out_o
);

  typedef enum logic [2:0] {
    PhIdle, PhSpace, PhPrefix, PhZero, PhDigits, PhDone
  } phase_e;

  phase_e                       ph_q, ph_d;
  logic                         neg_q, neg_d;
  logic [5:0]                   base_q, base_d, nbase_q;
  logic [31:0]                  acc_q, acc_d;
  logic [ispbd_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                         emit;
  logic                         out_vld_q;
  logic signed [31:0]           val_q;
  logic [15:0]                  off_q;

  assign cfg_i.ready        = 1'b1;
  assign pop_o              = !empty_i && (!out_vld_q || out_o.ready);
  assign out_o.valid        = out_vld_q;
  assign out_o.parsed_value = val_q;
  assign out_o.end_offset   = off_q;

  always_comb begin
    logic done;
    logic bump;
    done  = 1'b0;
    bump  = 1'b0;
    emit  = 1'b0;
    ph_d  = ph_q;
    neg_d = neg_q;
    base_d = base_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cls_i.start) begin
      ph_d   = PhSpace;
      neg_d  = 1'b0;
      base_d = nbase_q;
      acc_d  = '0;
      cnt_d  = '0;
    end
    if (ph_d == PhIdle || ph_d == PhDone) begin
      done = 1'b1;
    end
    if (!done && ph_d == PhSpace) begin
      if (cls_i.blank) begin
        bump = 1'b1;
        done = 1'b1;
      end else if (cls_i.plus || cls_i.minus) begin
        neg_d = cls_i.minus;
        bump  = 1'b1;
        ph_d  = PhPrefix;
        done  = 1'b1;
      end else begin
        ph_d = PhPrefix;
      end
    end
    if (!done && ph_d == PhPrefix) begin
      if ((base_d == ispbd_pkg::BaseAuto || base_d == ispbd_pkg::BaseHex) && cls_i.zero) begin
        bump = 1'b1;
        ph_d = PhZero;
        done = 1'b1;
      end else begin
        if (base_d == ispbd_pkg::BaseAuto) begin
          base_d = ispbd_pkg::BaseDec;
        end
        ph_d = PhDigits;
      end
    end else if (!done && ph_d == PhZero) begin
      if (cls_i.ex) begin
        base_d = ispbd_pkg::BaseHex;
        bump   = 1'b1;
        ph_d   = PhDigits;
        done   = 1'b1;
      end else begin
        if (base_d == ispbd_pkg::BaseAuto) begin
          base_d = ispbd_pkg::BaseOct;
        end
        ph_d = PhDigits;
      end
    end
    if (!done) begin
      if (!cls_i.digit[4] && ({1'b0, cls_i.digit} < base_d)) begin
        acc_d = (acc_d * 32'(base_d)) + 32'(cls_i.digit[3:0]);
        bump  = 1'b1;
      end else begin
        ph_d = PhDone;
        emit = 1'b1;
      end
    end
    if (bump && cnt_d != ispbd_pkg::CountMax) begin
      cnt_d = cnt_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PhIdle;
      neg_q     <= 1'b0;
      base_q    <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      nbase_q   <= ispbd_pkg::BaseReset;
      out_vld_q <= 1'b0;
      val_q     <= '0;
      off_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        nbase_q <= cfg_i.number_base;
      end
      if (pop_o) begin
        ph_q   <= ph_d;
        neg_q  <= neg_d;
        base_q <= base_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
      end
      if (pop_o && emit) begin
        out_vld_q <= 1'b1;
        val_q     <= neg_d ? $signed(32'd0 - acc_d) : $signed(acc_d);
        off_q     <= 16'(cnt_d);
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/integer_string_parser_base_detect_unit_test.sv =====
// Self-checking bench for the streaming integer parser: strings in, value and end offset out.
`timescale 1ns / 1ps

module integer_string_parser_base_detect_unit_test;

  typedef enum logic [2:0] {
    ST_WAIT, ST_LEAD, ST_SIGN_SEEN, ST_LEAD_ZERO, ST_DIGITS, ST_DONE
  } scan_state_e;

  typedef struct {
    logic signed [31:0] value;
    logic [15:0]        offset;
  } parse_result_t;

  class parse_result_board;
    logic [5:0]    base_reg = ispbd_pkg::BaseReset;
    scan_state_e   st = ST_WAIT;
    logic          minus = 1'b0;
    logic [5:0]    radix = '0;
    logic [31:0]   acc = '0;
    logic [15:0]   used = '0;
    parse_result_t pending_results[$];
    int            errors = 0;

    function void bump();
      if (used < ispbd_pkg::CountMax) used++;
    endfunction

    function void note_char(logic [7:0] ch, logic first);
      logic [4:0]    dv;
      parse_result_t r;
      if (first) begin
        st = ST_LEAD;
        minus = 1'b0;
        radix = base_reg;
        acc = '0;
        used = '0;
      end
      if (st == ST_WAIT || st == ST_DONE) return;
      if (st == ST_LEAD) begin
        if (ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
          bump();
          return;
        end
        if (ch == "+" || ch == "-") begin
          minus = (ch == "-");
          bump();
          st = ST_SIGN_SEEN;
          return;
        end
        st = ST_SIGN_SEEN;
      end
      if (st == ST_SIGN_SEEN) begin
        if ((radix == ispbd_pkg::BaseAuto || radix == ispbd_pkg::BaseHex) && ch == "0") begin
          bump();
          st = ST_LEAD_ZERO;
          return;
        end
        if (radix == ispbd_pkg::BaseAuto) radix = ispbd_pkg::BaseDec;
        st = ST_DIGITS;
      end else if (st == ST_LEAD_ZERO) begin
        if (ch == "x" || ch == "X") begin
          radix = ispbd_pkg::BaseHex;
          bump();
          st = ST_DIGITS;
          return;
        end
        if (radix == ispbd_pkg::BaseAuto) radix = ispbd_pkg::BaseOct;
        st = ST_DIGITS;
      end
      if (ch >= "0" && ch <= "9") dv = 5'(ch - "0");
      else if (ch >= "a" && ch <= "f") dv = 5'(ch - "a" + 10);
      else if (ch >= "A" && ch <= "F") dv = 5'(ch - "A" + 10);
      else dv = ispbd_pkg::DigitNone;
      if (dv != ispbd_pkg::DigitNone && dv < radix) begin
        acc = acc * {26'd0, radix} + {27'd0, dv};
        bump();
        return;
      end
      st = ST_DONE;
      r.value = minus ? -acc : acc;
      r.offset = used;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] value, logic [15:0] offset);
      parse_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, value %0d offset %0d", $time, value, offset);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (value !== e.value) begin
        $display("%0t: parsed_value expected %0d got %0d", $time, e.value, value);
        errors++;
      end
      if (offset !== e.offset) begin
        $display("%0t: end_offset expected %0d got %0d", $time, e.offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ispbd_in_if  in_if();
  ispbd_cfg_if cfg_if();
  ispbd_out_if out_if();

  integer_string_parser_base_detect_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  parse_result_board board = new();

  int         src_idle = 0;
  int         snk_idle = 0;
  int         items_sent = 0;
  logic       pressure_req = 1'b0;
  logic       open_flag;
  logic [5:0] cur_base = ispbd_pkg::BaseReset;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int   hold;
    logic pressure_taken;
    hold = 0;
    pressure_taken = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pressure_req && !pressure_taken) begin
        hold = 150;
        pressure_taken = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result(out_if.parsed_value, out_if.end_offset);
    end
  end

  task automatic push_char(input logic [7:0] ch, input logic first);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.char_in <= ch;
    in_if.start_flag <= first;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_char(ch, first);
    items_sent++;
    @(negedge clk_i);
  endtask

  // a start may land mid-string now and then
  task automatic push_part(input logic [7:0] ch);
    push_char(ch, open_flag);
    open_flag = ($urandom_range(99) < 2);
  endtask

  task automatic push_random_string();
    logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    int         lim;
    int         n;
    int         v;
    logic [7:0] ch;
    open_flag = 1'b1;
    lim = (cur_base == ispbd_pkg::BaseAuto || cur_base > ispbd_pkg::BaseHex) ?
          16 : int'(cur_base);
    if (lim == 0) lim = 16;
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) push_part(blanks[$urandom_range(5)]);
    end
    case ($urandom_range(3))
      1: push_part("+");
      2: push_part("-");
      default: ;
    endcase
    case ($urandom_range(5))
      1: push_part("0");
      2: begin
        push_part("0");
        push_part("x");
      end
      3: begin
        push_part("0");
        push_part("X");
      end
      default: ;
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 8);
    repeat (n) begin
      v = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(lim - 1);
      if (v < 10) ch = 8'("0" + v);
      else ch = 8'(($urandom_range(1) ? "A" : "a") + v - 10);
      push_part(ch);
    end
    case ($urandom_range(3))
      0: push_part(8'h00);
      1: push_part(8'($urandom_range(255)));
      2: push_part("g");
      default: push_part(" ");
    endcase
    if ($urandom_range(9) == 0) push_char(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [5:0] b);
    cfg_if.valid <= 1'b1;
    cfg_if.number_base <= b;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.base_reg = b;
    cur_base = b;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [5:0] phase_base [10];
    phase_base = '{ispbd_pkg::BaseReset, ispbd_pkg::BaseAuto, ispbd_pkg::BaseHex, 6'd1,
                   6'd36, ispbd_pkg::BaseOct, 6'd63, 6'd2, ispbd_pkg::BaseDec,
                   ispbd_pkg::BaseAuto};
    in_if.valid = 1'b0;
    in_if.char_in = '0;
    in_if.start_flag = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.number_base = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every blank, sign, stray beat, bare sign, wrapping value
    push_char(" ", 1'b1);
    push_char(8'h09, 1'b0);
    push_char(8'h0A, 1'b0);
    push_char(8'h0D, 1'b0);
    push_char(8'h0B, 1'b0);
    push_char(8'h0C, 1'b0);
    push_char("-", 1'b0);
    push_char("9", 1'b0);
    push_char(8'h00, 1'b0);
    push_char("q", 1'b0);
    push_char("+", 1'b1);
    push_char("X", 1'b0);
    push_char("9", 1'b1);
    repeat (10) push_char("9", 1'b0);
    push_char(8'hFF, 1'b0);

    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        drain_results();
        write_base(phase_base[p]);
      end
      if (p < 4) begin
        src_idle = 21;
        snk_idle = 53;
      end else if (p < 7) begin
        src_idle = 53;
        snk_idle = 21;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      if (p == 5) pressure_req = 1'b1;
      while (items_sent < (p + 1) * 185) begin
        if ($urandom_range(99) < 15) push_char(8'($urandom_range(255)), $urandom_range(3) == 0);
        else push_random_string();
      end
    end

    drain_results();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
